// ===== hdl/spq_pkg.sv =====
package spq_pkg;

	localparam int QUEUE_DEPTH  = 16;
	localparam int PAYLOAD_BITS = 32;
	localparam int RANK_BITS    = 16;
	localparam int CNT_W        = $clog2(QUEUE_DEPTH + 1);

	// field widths on the ports
	localparam int DATA_W   = 32;
	localparam int PRIO_W   = 16;
	localparam int OCC_W    = 5;
	localparam int STATUS_W = 2;

	localparam int S_TDATA_W = ((DATA_W + PRIO_W + 7) / 8) * 8;
	localparam int M_FIELD_W = DATA_W + DATA_W + PRIO_W + 1 + OCC_W;
	localparam int M_TDATA_W = ((M_FIELD_W + 7) / 8) * 8;
	localparam int M_TUSER_W = 1 + STATUS_W;

	localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

	localparam logic MODE_ENQ = 1'b0;
	localparam logic MODE_DEQ = 1'b1;

	typedef struct packed {
		logic                        valid;
		logic signed [RANK_BITS-1:0] rank;
		logic [PAYLOAD_BITS-1:0]     payload;
	} spq_entry_t;

	typedef struct packed {
		logic enq;
		logic deq;
	} spq_cmd_t;

endpackage

// ===== hdl/spq_cell.sv =====
module spq_cell
	import spq_pkg::*;
(
	input  logic                        clk,
	input  logic                        arst_n,
	input  spq_cmd_t                    cmd,
	input  logic signed [RANK_BITS-1:0] new_rank,
	input  logic [PAYLOAD_BITS-1:0]     new_payload,
	input  spq_entry_t                  left_ent,
	input  logic                        left_stay,
	input  spq_entry_t                  right_ent,
	output spq_entry_t                  ent,
	output spq_entry_t                  ent_nxt,
	output logic                        stay
);

	logic                        valid_q;
	logic signed [RANK_BITS-1:0] rank_q;
	logic [PAYLOAD_BITS-1:0]     payload_q;

	assign ent.valid   = valid_q;
	assign ent.rank    = rank_q;
	assign ent.payload = payload_q;

	// ties stay in front of a new item, so equal ranks leave in arrival order
	assign stay = valid_q && (rank_q <= new_rank);

	always_comb begin
		ent_nxt = ent;
		if (cmd.enq) begin
			if (stay) begin
				ent_nxt = ent;
			end else if (left_stay) begin
				ent_nxt.valid   = 1'b1;
				ent_nxt.rank    = new_rank;
				ent_nxt.payload = new_payload;
			end else begin
				ent_nxt = left_ent;
			end
		end else if (cmd.deq) begin
			ent_nxt = right_ent;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= ent_nxt.valid;
		end
	end

	always_ff @(posedge clk) begin
		rank_q    <= ent_nxt.rank;
		payload_q <= ent_nxt.payload;
	end

endmodule

// ===== hdl/sorted_priority_queue.sv =====
// Min-first priority queue of QUEUE_DEPTH entries held in a row of cells
// kept in ascending rank order; equal ranks leave in arrival order. Each
// input transaction (tuser 0 enqueue, 1 dequeue) yields one result
// transaction in the cycle after it is taken. A new transaction is taken
// every cycle as long as the result register is empty or being drained:
// every cell compares its rank with the incoming one in parallel and then
// keeps its entry, takes the new one, or takes its neighbor's, so the
// whole row updates at once. Dequeue on empty and enqueue on full change
// nothing and report a status. No clearing pass is needed after reset.
module sorted_priority_queue
	import spq_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [S_TDATA_W-1:0] s_tdata,  // in_data, in_priority
	input  logic                 s_tuser,  // mode
	output logic                 m_tvalid,
	input  logic                 m_tready,
	// out_data, head_data, head_priority, not_empty, occupancy
	output logic [M_TDATA_W-1:0] m_tdata,
	output logic [M_TUSER_W-1:0] m_tuser   // out_valid, status
);

	logic                        s_acc;
	logic [DATA_W-1:0]           in_data;
	logic signed [PRIO_W-1:0]    in_priority;
	logic signed [RANK_BITS-1:0] new_rank;
	logic [PAYLOAD_BITS-1:0]     new_payload;
	logic [CNT_W-1:0]            count_q;
	logic [CNT_W-1:0]            count_d;
	logic                        full;
	logic                        empty;
	spq_cmd_t                    cmd;
	spq_entry_t                  ents     [QUEUE_DEPTH];
	spq_entry_t                  ents_nxt [QUEUE_DEPTH];
	logic                        stays    [QUEUE_DEPTH];
	logic [QUEUE_DEPTH-1:0]      valid_vec;
	logic [STATUS_W-1:0]         status_d;

	logic                     m_tvalid_q;
	logic [DATA_W-1:0]        out_data_q;
	logic                     out_valid_q;
	logic [STATUS_W-1:0]      status_q;
	logic [DATA_W-1:0]        head_data_q;
	logic signed [PRIO_W-1:0] head_prio_q;
	logic                     not_empty_q;
	logic [OCC_W-1:0]         occ_q;

	assign s_tready    = !m_tvalid_q || m_tready;
	assign s_acc       = s_tvalid && s_tready;
	assign in_data     = s_tdata[DATA_W-1:0];
	assign in_priority = s_tdata[DATA_W+PRIO_W-1:DATA_W];
	assign new_rank    = RANK_BITS'(in_priority);
	assign new_payload = PAYLOAD_BITS'(in_data);

	assign full  = (count_q == CNT_W'(QUEUE_DEPTH));
	assign empty = (count_q == '0);

	assign cmd.enq = s_acc && (s_tuser == MODE_ENQ) && !full;
	assign cmd.deq = s_acc && (s_tuser == MODE_DEQ) && !empty;

	genvar gi;
	generate
		for (gi = 0; gi < QUEUE_DEPTH; gi++) begin : g_cell
			spq_entry_t left_ent;
			spq_entry_t right_ent;
			logic       left_stay;

			if (gi == 0) begin : g_first
				assign left_ent  = '0;
				assign left_stay = 1'b1;
			end else begin : g_mid
				assign left_ent  = ents[gi-1];
				assign left_stay = stays[gi-1];
			end

			if (gi == QUEUE_DEPTH - 1) begin : g_last
				assign right_ent = '0;
			end else begin : g_inner
				assign right_ent = ents[gi+1];
			end

			spq_cell u_cell (
				.clk         (clk),
				.arst_n      (arst_n),
				.cmd         (cmd),
				.new_rank    (new_rank),
				.new_payload (new_payload),
				.left_ent    (left_ent),
				.left_stay   (left_stay),
				.right_ent   (right_ent),
				.ent         (ents[gi]),
				.ent_nxt     (ents_nxt[gi]),
				.stay        (stays[gi])
			);

			assign valid_vec[gi] = ents[gi].valid;
		end
	endgenerate

	always_comb begin
		count_d = count_q;
		if (cmd.enq) begin
			count_d = count_q + CNT_W'(1);
		end else if (cmd.deq) begin
			count_d = count_q - CNT_W'(1);
		end
	end

	always_comb begin
		status_d = ST_OK;
		if (s_tuser == MODE_ENQ && full) begin
			status_d = ST_FULL;
		end else if (s_tuser == MODE_DEQ && empty) begin
			status_d = ST_EMPTY;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (s_acc) begin
				count_q <= count_d;
			end
			if (s_tready) begin
				m_tvalid_q <= s_tvalid;
			end
		end
	end

	// head view comes from the row's next state, valid bit zeroes an empty head
	always_ff @(posedge clk) begin
		if (s_acc) begin
			out_data_q  <= cmd.deq ? DATA_W'(ents[0].payload) : '0;
			out_valid_q <= cmd.deq;
			status_q    <= status_d;
			head_data_q <= ents_nxt[0].valid ? DATA_W'(ents_nxt[0].payload) : '0;
			head_prio_q <= ents_nxt[0].valid ? PRIO_W'(ents_nxt[0].rank) : '0;
			not_empty_q <= ents_nxt[0].valid;
			occ_q       <= OCC_W'(count_d);
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = M_TDATA_W'({occ_q, not_empty_q, head_prio_q, head_data_q, out_data_q});
	assign m_tuser  = {status_q, out_valid_q};

	// occupancy count tracks the cells holding entries
	a_count_matches: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(valid_vec) == int'(count_q))
		else $error("count does not match valid cells");

	// occupied cells form an unbroken run from the head
	a_valid_packed: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_vec & (valid_vec + QUEUE_DEPTH'(1))) == '0)
		else $error("hole in cell row");

	// head pair stays in rank order
	a_head_sorted: assert property (@(posedge clk) disable iff (!arst_n)
		ents[1].valid |-> (ents[0].rank <= ents[1].rank))
		else $error("head out of order");

	// a dequeue from a non-empty queue returns a payload
	a_deq_result: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.deq |=> (m_tvalid && m_tuser[0]))
		else $error("dequeue produced no payload");

endmodule

// ===== verif/tb.sv =====
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import spq_pkg::*;

	localparam int IDLE_LIMIT = 2000;
	localparam int MAX_SHOWN  = 10;

	typedef struct {
		logic [DATA_W-1:0]        payload;
		logic signed [PRIO_W-1:0] rank;
	} slot_t;

	typedef struct {
		logic [DATA_W-1:0]   out_data;
		logic                out_valid;
		logic [STATUS_W-1:0] status;
		logic [DATA_W-1:0]   head_data;
		logic [PRIO_W-1:0]   head_prio;
		logic                not_empty;
		logic [OCC_W-1:0]    occupancy;
	} reply_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [S_TDATA_W-1:0] s_tdata = '0;
	logic                 s_tuser = MODE_ENQ;
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [M_TDATA_W-1:0] m_tdata;
	logic [M_TUSER_W-1:0] m_tuser;

	sorted_priority_queue dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	// shadow copy of the queue contents, head first
	slot_t  ranked_slots[$];
	reply_t replies_due[$];

	int tx_gap_pct   = 0;
	int rx_stall_pct = 0;
	int rx_hold      = 0;
	int rx_stall_left = 0;
	int idle_cycles  = 0;

	int err_cnt      = 0;
	int items_sent   = 0;
	int replies_seen = 0;
	int enq_ok       = 0;
	int deq_ok       = 0;
	int empty_deqs   = 0;
	int full_drops   = 0;
	int tie_inserts  = 0;
	int max_fill     = 0;
	int input_stalls = 0;

	initial begin
		forever #10 clk = ~clk;
	end

	// mostly short, now and then long
	function automatic int pick_len();
		if ($urandom_range(9) == 0)
			return $urandom_range(8, 30);
		return $urandom_range(1, 3);
	endfunction

	function automatic int pick_gap(int pct);
		if ($urandom_range(99) >= pct)
			return 0;
		return pick_len();
	endfunction

	function automatic reply_t apply_op(logic mode, logic [DATA_W-1:0] data,
			logic signed [PRIO_W-1:0] prio);
		reply_t r;
		slot_t  s;
		int     pos;
		r = '{default: '0};
		r.status = ST_OK;
		if (mode == MODE_ENQ) begin
			if (ranked_slots.size() >= QUEUE_DEPTH) begin
				r.status = ST_FULL;
				full_drops++;
			end else begin
				// new entry lands behind everything of lower or equal rank
				pos = 0;
				while (pos < ranked_slots.size() && ranked_slots[pos].rank <= prio)
					pos++;
				if (pos > 0 && ranked_slots[pos-1].rank == prio)
					tie_inserts++;
				s.payload = data;
				s.rank = prio;
				ranked_slots.insert(pos, s);
				enq_ok++;
			end
		end else begin
			if (ranked_slots.size() == 0) begin
				r.status = ST_EMPTY;
				empty_deqs++;
			end else begin
				s = ranked_slots.pop_front();
				r.out_data = s.payload;
				r.out_valid = 1'b1;
				deq_ok++;
			end
		end
		if (ranked_slots.size() > 0) begin
			r.head_data = ranked_slots[0].payload;
			r.head_prio = ranked_slots[0].rank;
			r.not_empty = 1'b1;
		end
		r.occupancy = OCC_W'(ranked_slots.size());
		if (ranked_slots.size() > max_fill)
			max_fill = ranked_slots.size();
		return r;
	endfunction

	task automatic send_item(input logic mode, input logic [DATA_W-1:0] data,
			input logic [PRIO_W-1:0] prio);
		int gap;
		gap = pick_gap(tx_gap_pct);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= mode;
		s_tdata <= S_TDATA_W'({prio, data});
		do @(posedge clk); while (!s_tready);
		replies_due.push_back(apply_op(mode, data, prio));
		items_sent++;
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (replies_due.size() > 0)
			@(posedge clk);
	endtask

	task automatic check_field(input string name, input logic [DATA_W-1:0] want,
			input logic [DATA_W-1:0] got);
		if (got !== want) begin
			err_cnt++;
			if (err_cnt <= MAX_SHOWN)
				$display("%0t: %s mismatch, expected %h, got %h", $realtime, name,
					want, got);
		end
	endtask

	// receiver: random stalls, plus a long hold-off when requested
	initial begin
		forever begin
			@(posedge clk);
			if (rx_hold > 0) begin
				m_tready <= 1'b0;
				rx_hold--;
			end else if (rx_stall_left > 0) begin
				m_tready <= 1'b0;
				rx_stall_left--;
			end else if ($urandom_range(99) < rx_stall_pct) begin
				m_tready <= 1'b0;
				rx_stall_left = pick_len() - 1;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		reply_t want;
		if (arst_n && m_tvalid && m_tready) begin
			replies_seen++;
			if (replies_due.size() == 0) begin
				err_cnt++;
				if (err_cnt <= MAX_SHOWN)
					$display("%0t: result transaction with none pending, tdata %h tuser %h",
						$realtime, m_tdata, m_tuser);
			end else begin
				want = replies_due.pop_front();
				check_field("out_data", want.out_data, m_tdata[31:0]);
				check_field("out_valid", DATA_W'(want.out_valid), DATA_W'(m_tuser[0]));
				check_field("status", DATA_W'(want.status), DATA_W'(m_tuser[2:1]));
				check_field("head_data", want.head_data, m_tdata[63:32]);
				check_field("head_priority", DATA_W'(want.head_prio),
					DATA_W'(m_tdata[79:64]));
				check_field("not_empty", DATA_W'(want.not_empty), DATA_W'(m_tdata[80]));
				check_field("occupancy", DATA_W'(want.occupancy),
					DATA_W'(m_tdata[85:81]));
			end
		end
	end

	// watchdog on cycles without any transaction
	always @(posedge clk) begin
		if (s_tvalid && !s_tready)
			input_stalls++;
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("timeout: %0d cycles without a transaction", IDLE_LIMIT);
			$display("simulation failed");
			$finish;
		end
	end

	task automatic test_empty_dequeue();
		send_item(MODE_DEQ, $urandom, PRIO_W'($urandom));
		send_item(MODE_DEQ, 32'hFFFF_FFFF, 16'h8000);
	endtask

	// extremes of rank and payload, ties at both rank extremes and at zero, then overflow and three dequeues
	task automatic test_order_and_overflow();
		logic [PRIO_W-1:0] ranks[8] = '{16'h7FFF, 16'h8000, 16'h0000, 16'hFFFF,
			16'h0001, 16'h0000, 16'h8000, 16'h7FFF};
		logic [DATA_W-1:0] words[8] = '{32'hFFFF_FFFF, 32'h0000_0000, 32'h8000_0000,
			32'h0000_0001, 32'h7FFF_FFFF, 32'hA5A5_5A5A, 32'h1234_5678, 32'hFFFF_FFFE};
		for (int i = 0; i < 8; i++)
			send_item(MODE_ENQ, words[i], ranks[i]);
		for (int i = 0; i < QUEUE_DEPTH - 8; i++)
			send_item(MODE_ENQ, 32'hC000_0000 + i, 16'd5);
		send_item(MODE_ENQ, 32'hFFFF_FFFF, 16'h8000);
		repeat (3)
			send_item(MODE_DEQ, $urandom, PRIO_W'($urandom));
	endtask

	task automatic send_random(input int enq_pct, input int prio_style);
		logic [PRIO_W-1:0] prio;
		int                v;
		case (prio_style)
			0: prio = PRIO_W'($urandom);
			1: begin
				v = $urandom_range(6);
				v -= 3;
				prio = v[PRIO_W-1:0];
			end
			default: begin
				case ($urandom_range(3))
					0: prio = 16'h8000;
					1: prio = 16'h7FFF;
					2: prio = 16'hFFFF;
					default: prio = 16'h0000;
				endcase
			end
		endcase
		if ($urandom_range(99) < enq_pct)
			send_item(MODE_ENQ, $urandom, prio);
		else
			send_item(MODE_DEQ, $urandom, prio);
	endtask

	// result side held off while the sender keeps offering back to back
	task automatic test_backpressure();
		tx_gap_pct = 0;
		rx_hold = 200;
		repeat (40)
			send_random(75, 0);
	endtask

	task automatic test_random_mix();
		int enq_mix[8]   = '{85, 20, 50, 70, 30, 50, 90, 10};
		int gap_mix[8]   = '{20, 0, 40, 10, 0, 60, 25, 15};
		int stall_mix[8] = '{20, 30, 0, 50, 10, 0, 40, 15};
		for (int ph = 0; ph < 8; ph++) begin
			tx_gap_pct = gap_mix[ph];
			rx_stall_pct = stall_mix[ph];
			repeat (100)
				send_random(enq_mix[ph], $urandom_range(99) < 50 ? 0 :
					($urandom_range(1) ? 1 : 2));
			if (ph == 3)
				wait_drained();
		end
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		tx_gap_pct = 30;
		rx_stall_pct = 30;
		test_empty_dequeue();
		test_order_and_overflow();
		wait_drained();
		test_backpressure();
		wait_drained();
		test_random_mix();
		wait_drained();
		repeat (10) @(posedge clk);

		$display("%0d transactions in, %0d results: %0d enqueued, %0d dequeued, %0d ties",
			items_sent, replies_seen, enq_ok, deq_ok, tie_inserts);
		$display("%0d dequeues on empty, %0d dropped when full, peak fill %0d, %0d input stalls",
			empty_deqs, full_drops, max_fill, input_stalls);
		if (err_cnt == 0 && replies_due.size() == 0) begin
			$display("simulation ok");
		end else begin
			$display("%0d mismatches, %0d results missing", err_cnt, replies_due.size());
			$display("simulation failed");
		end
		$finish;
	end

endmodule
